// ----- hdl/ss_pkg.sv -----
// Shared types and constants for the streaming substring search block.
// Used by the channel interfaces, the match cells, the controller and the top level.
package ss_pkg;

   localparam int TEXT_WIDTH             = 8;
   localparam int OFFSET_WIDTH           = 16;
   localparam int LENGTH_WIDTH           = 5;
   localparam int CSR_DATA_WIDTH         = 64;
   localparam int CSR_INDEX_WIDTH        = 2;
   localparam int PATTERN_BYTES          = 16;
   localparam int DEFAULT_MAX_PATTERN    = 16;
   localparam int DEFAULT_POSITION_WIDTH = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_LENGTH = 2'd2;

   typedef logic [TEXT_WIDTH-1:0] text_byte_type;

   typedef struct packed {
      logic          step;
      logic          clear;
      text_byte_type text_byte;
   } cell_ctrl_type;

endpackage

// ----- hdl/ss_req_if.sv -----
// Input channel of the substring search block: one text byte per item.
// Depends on ss_pkg for the byte type.
interface ss_req_if import ss_pkg::*; ();
   logic          valid;
   logic          ready;
   text_byte_type text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

// ----- hdl/ss_rsp_if.sv -----
// Result channel of the substring search block: one search result per item.
// Depends on ss_pkg for the offset width.
interface ss_rsp_if import ss_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [OFFSET_WIDTH-1:0] match_offset;
   logic                    too_long;

   modport source (output valid, output found, output match_offset, output too_long,
                   input ready);
   modport sink (input valid, input found, input match_offset, input too_long,
                 output ready);
endinterface

// ----- hdl/substring_search_top.sv -----
// Streaming substring search: text bytes in, one result per zero-terminated text out.
// The block takes one text byte per cycle while req_ready is high. Every pattern
// position has a cell that compares the byte and passes its partial-match bit to the
// next cell, so all positions advance together. The result appears in the cycle after
// the zero byte that ends a text is taken, from an output register; new bytes are taken
// while that result waits, and input stalls only while a held result is not taken and
// another would be needed in its place. The user must write pattern registers through
// the csr port only while no text is in flight; the block itself does not enforce it.
module substring_search_top import ss_pkg::*; #(
   parameter int MAX_PATTERN    = DEFAULT_MAX_PATTERN,
   parameter int POSITION_WIDTH = DEFAULT_POSITION_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   ss_req_if.sink                     req_if,
   ss_rsp_if.source                   rsp_if,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int USED_WIDTH = $clog2(MAX_PATTERN + 1);

   logic [CSR_DATA_WIDTH-1:0] pattern_low_ff;
   logic [CSR_DATA_WIDTH-1:0] pattern_high_ff;
   logic [LENGTH_WIDTH-1:0]   pattern_length_ff;

   logic [2*CSR_DATA_WIDTH-1:0] pattern_bits;
   logic [USED_WIDTH-1:0]       used_length;
   cell_ctrl_type               cell_ctrl;
   logic [MAX_PATTERN:0]        chain;
   logic [MAX_PATTERN-1:0]      cell_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_PATTERN_LOW: begin
               pattern_low_ff <= csr_write_data;
            end
            REG_PATTERN_HIGH: begin
               pattern_high_ff <= csr_write_data;
            end
            REG_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_write_data[LENGTH_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign pattern_bits = {pattern_high_ff, pattern_low_ff};

   always_comb begin
      if (32'(pattern_length_ff) > MAX_PATTERN) begin
         used_length = USED_WIDTH'(MAX_PATTERN);
      end else begin
         used_length = USED_WIDTH'(pattern_length_ff);
      end
   end

   assign chain[0] = 1'b1;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      text_byte_type pattern_byte;
      if (k < PATTERN_BYTES) begin : g_byte
         assign pattern_byte = pattern_bits[k*TEXT_WIDTH +: TEXT_WIDTH];
      end else begin : g_zero
         assign pattern_byte = '0;
      end
      ss_cell #(
         .INDEX      (k),
         .USED_WIDTH (USED_WIDTH)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .pattern_byte (pattern_byte),
         .used_length  (used_length),
         .prev_match   (chain[k]),
         .match        (chain[k+1]),
         .hit          (cell_hit[k])
      );
   end

   ss_ctrl #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .USED_WIDTH     (USED_WIDTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_text_byte    (req_if.text_byte),
      .used_length      (used_length),
      .hit              (|cell_hit),
      .cell_ctrl        (cell_ctrl),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_found        (rsp_if.found),
      .rsp_match_offset (rsp_if.match_offset),
      .rsp_too_long     (rsp_if.too_long)
   );

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && (req_if.text_byte == '0) |=> rsp_if.valid)
      else $error("ending a text did not raise a result");

   a_found_excludes_too_long: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.found && rsp_if.too_long))
      else $error("result is both found and too long");

   a_miss_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.found |-> rsp_if.match_offset == '0)
      else $error("result without a match carries a nonzero offset");

   a_one_hit_cell: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_hit))
      else $error("more than one cell reports a completed match");

endmodule

// ----- hdl/ss_cell.sv -----
// One pattern cell: holds the partial-match bit for one pattern position.
// Depends on ss_pkg; instantiated in a chain by substring_search_top.
module ss_cell import ss_pkg::*; #(
   parameter int INDEX        = 0,
   parameter int USED_WIDTH   = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  text_byte_type         pattern_byte,
   input  logic [USED_WIDTH-1:0] used_length,
   input  logic                  prev_match,
   output logic                  match,
   output logic                  hit
);

   logic match_ff;
   logic match_in;
   logic in_use;
   logic is_last;

   always_comb begin
      in_use  = 32'(used_length) > INDEX;
      is_last = 32'(used_length) == INDEX + 1;
      match_in = match_ff;
      if (ctrl.clear) begin
         match_in = 1'b0;
      end else if (ctrl.step) begin
         match_in = in_use && prev_match && (ctrl.text_byte == pattern_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match = match_ff;
   assign hit   = ctrl.step && is_last && match_in;

endmodule

// ----- hdl/ss_ctrl.sv -----
// Controller: text position, first-match tracking, saturation and the result register.
// Depends on ss_pkg; drives the cell chain through a cell_ctrl_type struct.
module ss_ctrl import ss_pkg::*; #(
   parameter int POSITION_WIDTH = DEFAULT_POSITION_WIDTH,
   parameter int USED_WIDTH     = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  text_byte_type           req_text_byte,
   input  logic [USED_WIDTH-1:0]   used_length,
   input  logic                    hit,
   output cell_ctrl_type           cell_ctrl,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [OFFSET_WIDTH-1:0] rsp_match_offset,
   output logic                    rsp_too_long
);

   logic [POSITION_WIDTH-1:0] position_ff, position_in;
   logic [POSITION_WIDTH-1:0] first_start_ff, first_start_in;
   logic                      match_seen_ff, match_seen_in;
   logic                      saturated_ff, saturated_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [OFFSET_WIDTH-1:0]   rsp_offset_ff, rsp_offset_in;
   logic                      rsp_too_long_ff, rsp_too_long_in;

   logic                                   accept;
   logic                                   end_of_text;
   logic                                   empty_pattern;
   logic                                   found_now;
   logic [POSITION_WIDTH+OFFSET_WIDTH-1:0] start_wide;

   assign req_ready     = !end_of_text || !rsp_valid_ff || rsp_ready;
   assign accept        = req_valid && req_ready;
   assign end_of_text   = req_text_byte == '0;
   assign empty_pattern = used_length == '0;
   assign found_now     = match_seen_ff || empty_pattern;
   assign start_wide    = {{OFFSET_WIDTH{1'b0}}, first_start_ff};

   always_comb begin
      cell_ctrl.text_byte = req_text_byte;
      cell_ctrl.clear     = accept && end_of_text;
      cell_ctrl.step      = accept && !end_of_text && !match_seen_ff && !saturated_ff
                            && !empty_pattern && (position_ff != '1);

      position_in     = position_ff;
      first_start_in  = first_start_ff;
      match_seen_in   = match_seen_ff;
      saturated_in    = saturated_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_found_in    = rsp_found_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_too_long_in = rsp_too_long_ff;

      if (accept && end_of_text) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = found_now;
         rsp_offset_in   = found_now ? start_wide[OFFSET_WIDTH-1:0] : '0;
         rsp_too_long_in = !found_now && saturated_ff;
         position_in     = '0;
         first_start_in  = '0;
         match_seen_in   = 1'b0;
         saturated_in    = 1'b0;
      end else if (accept && !match_seen_ff && !saturated_ff) begin
         if (empty_pattern) begin
            match_seen_in  = 1'b1;
            first_start_in = '0;
         end else if (position_ff == '1) begin
            saturated_in = 1'b1;
         end else begin
            position_in = position_ff + POSITION_WIDTH'(1);
            if (hit) begin
               match_seen_in  = 1'b1;
               first_start_in = position_ff - (POSITION_WIDTH'(used_length)
                                               - POSITION_WIDTH'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         first_start_ff <= '0;
         match_seen_ff  <= 1'b0;
         saturated_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         position_ff    <= position_in;
         first_start_ff <= first_start_in;
         match_seen_ff  <= match_seen_in;
         saturated_ff   <= saturated_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff    <= rsp_found_in;
      rsp_offset_ff   <= rsp_offset_in;
      rsp_too_long_ff <= rsp_too_long_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;
   assign rsp_too_long     = rsp_too_long_ff;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for substring_search_top: streams text bytes, predicts every result.
// Depends on ss_pkg and the ss_req_if / ss_rsp_if channel interfaces from the RTL.
`timescale 1ns / 1ps

module tb;
   import ss_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 850;
   localparam int POS_LAST       = (1 << DEFAULT_POSITION_WIDTH) - 1;

   typedef struct packed {
      logic                    found;
      logic [OFFSET_WIDTH-1:0] match_offset;
      logic                    too_long;
   } search_result_type;

   typedef logic [TEXT_WIDTH-1:0] byte_q_type[$];

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   ss_req_if req_ch ();
   ss_rsp_if rsp_ch ();

   substring_search_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Mirror of the configuration and the search state.
   logic [63:0]                     pat_low_copy;
   logic [63:0]                     pat_high_copy;
   logic [LENGTH_WIDTH-1:0]         pat_len_copy;
   logic [PATTERN_BYTES-1:0]        partial_bits;
   logic [DEFAULT_POSITION_WIDTH:0] text_pos;
   logic                            match_seen;
   logic [OFFSET_WIDTH-1:0]         first_start;
   logic                            pos_saturated;

   byte_q_type        pending_bytes;
   search_result_type expected_results[$];
   logic [7:0]        next_pattern[PATTERN_BYTES];

   int burst_left;
   int gap_left;
   int rx_mode;
   int rx_period;
   int rx_stall;
   int rx_count;
   int idle_cycles;
   int mismatches;
   int items_sent;
   int results_checked;
   int found_count;
   int too_long_count;

   always #5 clock = ~clock;

   task automatic search_step(input logic [TEXT_WIDTH-1:0] b);
      int                eff;
      logic [127:0]      pat;
      search_result_type r;
      eff = (pat_len_copy > PATTERN_BYTES) ? PATTERN_BYTES : pat_len_copy;
      pat = {pat_high_copy, pat_low_copy};
      if (b == '0) begin
         r.found        = match_seen || (eff == 0);
         r.match_offset = r.found ? first_start : '0;
         r.too_long     = !r.found && pos_saturated;
         expected_results.push_back(r);
         partial_bits  = '0;
         text_pos      = '0;
         match_seen    = 1'b0;
         first_start   = '0;
         pos_saturated = 1'b0;
      end else if (!match_seen && !pos_saturated) begin
         if (eff == 0) begin
            match_seen  = 1'b1;
            first_start = '0;
         end else if (text_pos >= POS_LAST) begin
            pos_saturated = 1'b1;
         end else begin
            for (int k = PATTERN_BYTES - 1; k >= 0; k--) begin
               if (k >= eff)
                  partial_bits[k] = 1'b0;
               else
                  partial_bits[k] = ((k == 0) ? 1'b1 : partial_bits[k-1])
                                    && (b == pat[8*k +: 8]);
            end
            if (partial_bits[eff-1]) begin
               match_seen  = 1'b1;
               first_start = OFFSET_WIDTH'(text_pos - (eff - 1));
            end
            text_pos++;
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         REG_PATTERN_LOW:    pat_low_copy = data;
         REG_PATTERN_HIGH:   pat_high_copy = data;
         REG_PATTERN_LENGTH: pat_len_copy = data[LENGTH_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_ch.valid || expected_results.size() != 0);
   endtask

   // Waits for the block to drain, then loads next_pattern and the length word.
   task automatic start_phase(input logic [CSR_DATA_WIDTH-1:0] len_word, input int mode);
      logic [63:0] lo;
      logic [63:0] hi;
      for (int k = 0; k < 8; k++) begin
         lo[8*k +: 8] = next_pattern[k];
         hi[8*k +: 8] = next_pattern[k+8];
      end
      wait_idle();
      repeat (4) @(posedge clock);
      write_reg(REG_PATTERN_LOW, lo);
      write_reg(REG_PATTERN_HIGH, hi);
      write_reg(REG_PATTERN_LENGTH, len_word);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      rx_mode   = mode;
      rx_period = $urandom_range(2, 8);
      rx_stall  = $urandom_range(1, rx_period - 1);
   endtask

   task automatic queue_text(input byte_q_type t);
      foreach (t[i]) pending_bytes.push_back(t[i]);
      pending_bytes.push_back('0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            search_step(req_ch.text_byte);
            items_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 32);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (burst_left > 0 && pending_bytes.size() > 0) begin
               req_ch.valid     <= 1'b1;
               req_ch.text_byte <= pending_bytes.pop_front();
               burst_left--;
            end else begin
               req_ch.valid <= 1'b0;
               if (burst_left == 0) gap_left--;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_count = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               if (mismatches < 10)
                  $display("ERROR: unexpected result found=%0b offset=%0d too_long=%0b",
                           rsp_ch.found, rsp_ch.match_offset, rsp_ch.too_long);
               mismatches++;
            end else begin
               automatic search_result_type e = expected_results.pop_front();
               if (rsp_ch.found !== e.found || rsp_ch.match_offset !== e.match_offset
                   || rsp_ch.too_long !== e.too_long) begin
                  if (mismatches < 10)
                     $display({"ERROR: result %0d expected found=%0b offset=%0d ",
                               "too_long=%0b, got found=%0b offset=%0d too_long=%0b"},
                              results_checked, e.found, e.match_offset, e.too_long,
                              rsp_ch.found, rsp_ch.match_offset, rsp_ch.too_long);
                  mismatches++;
               end
               if (e.found) found_count++;
               if (e.too_long) too_long_count++;
            end
            results_checked++;
         end
         case (rx_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 2) != 0);
            default: rsp_ch.ready <= ((rx_count % rx_period) >= rx_stall);
         endcase
         rx_count++;
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      byte_q_type                t;
      logic [CSR_DATA_WIDTH-1:0] len_word;
      logic [7:0]                alpha[3];
      int                        eff;
      int                        tlen;
      int                        kind;
      int                        at;
      int                        queued;
      int                        phase_items;
      bit                        has_zero;

      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.text_byte = '0;
      rsp_ch.ready     = 1'b0;
      pat_low_copy     = '0;
      pat_high_copy    = '0;
      pat_len_copy     = '0;
      partial_bits     = '0;
      text_pos         = '0;
      match_seen       = 1'b0;
      first_start      = '0;
      pos_saturated    = 1'b0;
      rx_mode          = 0;
      rx_period        = 2;
      rx_stall         = 1;
      idle_cycles      = 0;
      mismatches       = 0;
      items_sent       = 0;
      results_checked  = 0;
      found_count      = 0;
      too_long_count   = 0;
      queued           = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The empty pattern after reset matches at offset zero, even in an empty text.
      t = {};
      queue_text(t);
      t = {8'h41, 8'hFF};
      queue_text(t);

      // Two-byte pattern at the byte extremes; bytes after the first match are ignored.
      foreach (next_pattern[k]) next_pattern[k] = 8'($urandom());
      next_pattern[0] = 8'h01;
      next_pattern[1] = 8'hFF;
      start_phase(64'd2, 0);
      t = {8'h01, 8'h01, 8'hFF, 8'h01, 8'hFF};
      queue_text(t);
      t = {8'hFF, 8'h01};
      queue_text(t);

      // A length word above the maximum, with junk in the unused bits, acts as 16.
      foreach (next_pattern[k]) next_pattern[k] = 8'($urandom_range(1, 255));
      start_phase({{(CSR_DATA_WIDTH-LENGTH_WIDTH){1'b1}}, 5'd31}, 1);
      t = {};
      foreach (next_pattern[k]) t.push_back(next_pattern[k]);
      queue_text(t);

      while (queued < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0:       len_word = 64'd0;
            1:       len_word = 64'd1;
            2:       len_word = 64'd16;
            3:       len_word = CSR_DATA_WIDTH'($urandom_range(17, 31));
            default: len_word = CSR_DATA_WIDTH'($urandom_range(2, 15));
         endcase
         if ($urandom_range(0, 3) == 0)
            len_word[CSR_DATA_WIDTH-1:LENGTH_WIDTH] =
               (CSR_DATA_WIDTH-LENGTH_WIDTH)'({$urandom(), $urandom()});
         eff = (len_word[LENGTH_WIDTH-1:0] > PATTERN_BYTES) ? PATTERN_BYTES
                                                            : len_word[LENGTH_WIDTH-1:0];
         if ($urandom_range(0, 3) == 0) begin
            alpha[0] = 8'h01;
            alpha[1] = 8'h80;
            alpha[2] = 8'hFF;
         end else begin
            foreach (alpha[i]) alpha[i] = 8'($urandom_range(1, 255));
         end
         foreach (next_pattern[k])
            next_pattern[k] = (k < eff) ? alpha[$urandom_range(0, 2)] : 8'($urandom());
         has_zero = (eff > 0) && ($urandom_range(0, 5) == 0);
         if (has_zero) next_pattern[$urandom_range(0, eff - 1)] = 8'h00;
         start_phase(len_word, $urandom_range(0, 2));

         phase_items = 0;
         while (phase_items < 60 + $urandom_range(0, 30)) begin
            tlen = $urandom_range(0, 24);
            kind = $urandom_range(0, 9);
            t = {};
            for (int i = 0; i < tlen; i++)
               t.push_back((kind == 7 || kind == 8) ? 8'($urandom_range(1, 255))
                                                     : alpha[$urandom_range(0, 2)]);
            if (eff > 0 && eff <= tlen && (kind < 5 || kind == 9)) begin
               at = $urandom_range(0, tlen - eff);
               for (int k = 0; k < eff; k++)
                  t[at + k] = (next_pattern[k] != 0) ? next_pattern[k] : alpha[0];
               // A broken copy: the last byte of the pattern is replaced.
               if (kind == 9)
                  t[at + eff - 1] = 8'(t[at + eff - 1] + 8'd1 + $urandom_range(0, 253));
               if (t[at + eff - 1] == 0) t[at + eff - 1] = 8'h01;
            end
            queue_text(t);
            phase_items += tlen + 1;
         end
         queued += phase_items;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Sent %0d text bytes, checked %0d results (%0d found, %0d too long).",
               items_sent, results_checked, found_count, too_long_count);
      $display("Mismatches: %0d, results still expected: %0d.",
               mismatches, expected_results.size());
      if (mismatches == 0 && expected_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
